// ===== rtl/adts_pkg.sv =====
package adts_pkg;

  // Results one input byte can cause: six held header bytes, the byte itself
  // and an end-of-stream marker.
  localparam int MAX_RES = 8;
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam int NRES_W  = $clog2(MAX_RES + 1);

  // Default result queue depth (power of two, at least MAX_RES).
  localparam int QDEPTH  = 16;

  localparam int LEN_W   = 13;
  localparam int HDR_STORE = 6;

  localparam logic [7:0]       SYNC_BYTE  = 8'hFF;
  localparam logic [3:0]       SYNC_NIB   = 4'hF;
  localparam logic [LEN_W-1:0] HDR_LEN    = 13'd7;
  localparam logic [LEN_W-1:0] HDR_STORED = 13'd6;

  localparam logic [1:0] ST_BYTE   = 2'd0;
  localparam logic [1:0] ST_BADLEN = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic             first_of_frame;
    logic             last_of_frame;
    logic [LEN_W-1:0] frame_length;
    logic [1:0]       status;
  } res_t;

endpackage

// ===== rtl/adts_parse.sv =====
module adts_parse (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     fire,
  input  logic [7:0]                               data_byte,
  input  logic                                     end_of_input,
  output logic [adts_pkg::NRES_W-1:0]              res_n,
  output adts_pkg::res_t [adts_pkg::MAX_RES-1:0]   res
);

  adts_pkg::phase_t              phase_r, phase_nxt;
  logic                          prev_ff_r, prev_ff_nxt;
  logic [adts_pkg::LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [adts_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [7:0]                    hdr_r   [adts_pkg::HDR_STORE];
  logic [7:0]                    hdr_nxt [adts_pkg::HDR_STORE];
  logic [adts_pkg::LEN_W-1:0]    hdr_len;
  logic [adts_pkg::LEN_W-1:0]    cnt_inc;

  function automatic adts_pkg::res_t mk_res(
    input logic [7:0]                 b,
    input logic                       first,
    input logic                       last,
    input logic [adts_pkg::LEN_W-1:0] len,
    input logic [1:0]                 st
  );
    adts_pkg::res_t r;
    r.frame_byte     = b;
    r.first_of_frame = first;
    r.last_of_frame  = last;
    r.frame_length   = len;
    r.status         = st;
    return r;
  endfunction

  // Length field: 2 bits of byte 3, all of byte 4, top 3 bits of byte 5.
  assign hdr_len = {hdr_r[3][1:0], hdr_r[4], hdr_r[5][7:5]};
  assign cnt_inc = cnt_r + 13'd1;

  always_comb begin
    phase_nxt   = phase_r;
    prev_ff_nxt = prev_ff_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    hdr_nxt     = hdr_r;
    res         = '0;
    res_n       = '0;
    if (fire) begin
      case (phase_r)
        adts_pkg::PH_HEADER: begin
          if (cnt_r < adts_pkg::HDR_STORED) begin
            hdr_nxt[cnt_r[2:0]] = data_byte;
            cnt_nxt             = cnt_inc;
          end else begin
            len_nxt = hdr_len;
            if (hdr_len < adts_pkg::HDR_LEN) begin
              res[0]      = mk_res(8'h00, 1'b0, 1'b1, hdr_len, adts_pkg::ST_BADLEN);
              res_n       = adts_pkg::NRES_W'(1);
              phase_nxt   = adts_pkg::PH_HUNT;
              prev_ff_nxt = 1'b0;
              cnt_nxt     = '0;
            end else begin
              for (int i = 0; i < adts_pkg::HDR_STORE; i++) begin
                res[i] = mk_res(hdr_r[i], (i == 0), 1'b0, hdr_len, adts_pkg::ST_BYTE);
              end
              res[adts_pkg::HDR_STORE] = mk_res(data_byte, 1'b0,
                                                hdr_len == adts_pkg::HDR_LEN,
                                                hdr_len, adts_pkg::ST_BYTE);
              res_n = adts_pkg::NRES_W'(adts_pkg::HDR_STORE + 1);
              if (hdr_len == adts_pkg::HDR_LEN) begin
                phase_nxt   = adts_pkg::PH_HUNT;
                prev_ff_nxt = 1'b0;
                cnt_nxt     = '0;
              end else begin
                phase_nxt = adts_pkg::PH_PAYLOAD;
                cnt_nxt   = adts_pkg::HDR_LEN;
              end
            end
          end
        end
        adts_pkg::PH_PAYLOAD: begin
          res_n = adts_pkg::NRES_W'(1);
          if (cnt_inc >= len_r) begin
            res[0]      = mk_res(data_byte, 1'b0, 1'b1, len_r, adts_pkg::ST_BYTE);
            phase_nxt   = adts_pkg::PH_HUNT;
            prev_ff_nxt = 1'b0;
            cnt_nxt     = '0;
          end else begin
            res[0]  = mk_res(data_byte, 1'b0, 1'b0, len_r, adts_pkg::ST_BYTE);
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          phase_nxt = adts_pkg::PH_HUNT;
          if (prev_ff_r && (data_byte[7:4] == adts_pkg::SYNC_NIB)) begin
            hdr_nxt[0]  = adts_pkg::SYNC_BYTE;
            hdr_nxt[1]  = data_byte;
            cnt_nxt     = 13'd2;
            len_nxt     = '0;
            phase_nxt   = adts_pkg::PH_HEADER;
            prev_ff_nxt = 1'b0;
          end else begin
            prev_ff_nxt = (data_byte == adts_pkg::SYNC_BYTE);
          end
        end
      endcase

      if (end_of_input) begin
        // open frame at end of stream: append truncation marker
        if (phase_nxt == adts_pkg::PH_HEADER || phase_nxt == adts_pkg::PH_PAYLOAD) begin
          res[res_n[adts_pkg::IDX_W-1:0]] =
            mk_res(8'h00, 1'b0, 1'b1,
                   (phase_nxt == adts_pkg::PH_PAYLOAD) ? len_nxt : '0,
                   adts_pkg::ST_TRUNC);
          res_n = res_n + adts_pkg::NRES_W'(1);
        end
        phase_nxt   = adts_pkg::PH_HUNT;
        prev_ff_nxt = 1'b0;
        cnt_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= adts_pkg::PH_HUNT;
      prev_ff_r <= 1'b0;
      cnt_r     <= '0;
      len_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      prev_ff_r <= prev_ff_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

// ===== rtl/adts_rq.sv =====
module adts_rq #(
  parameter int DEPTH = adts_pkg::QDEPTH
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [adts_pkg::NRES_W-1:0]              push_n,
  input  adts_pkg::res_t [adts_pkg::MAX_RES-1:0]   push_res,
  input  logic                                     pop,
  output adts_pkg::res_t                           head,
  output logic [$clog2(DEPTH+1)-1:0]               count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  adts_pkg::res_t  mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  function automatic logic NRES_W_LT(input int k, input logic [adts_pkg::NRES_W-1:0] n);
    return adts_pkg::NRES_W'(k) < n;
  endfunction

  assign count_nxt = count_r + CW'(push_n) - CW'(pop);
  assign head      = mem[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(push_n);
      rd_ptr_r <= rd_ptr_r + PW'(pop);
      count_r  <= count_nxt;
    end
  end

  // up to MAX_RES entries written per cycle at consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < adts_pkg::MAX_RES; k++) begin
      if (NRES_W_LT(k, push_n)) begin
        mem[wr_ptr_r + PW'(k)] <= push_res[k];
      end
    end
  end

endmodule

// ===== rtl/adts_frame_sync_deframer_top.sv =====
// Channel  Dir  Ports                                         Transfer when
// in       in   in_data_byte, in_end_of_input                 in_valid  && !in_stall
// out      out  out_frame_byte, out_first_of_frame,           out_valid && !out_stall
//               out_last_of_frame, out_frame_length, out_status
//
// One byte per cycle is taken while the result queue has room for a full
// burst (count <= QDEPTH - 8). Results leave at one per cycle while out_stall
// is low; a byte's results reach out_* via the input register and the queue.
// With a legal length the seventh header byte queues seven results, drained
// while payload bytes keep arriving. rst_n (synchronous) empties the queue
// and returns the parser to sync hunting. Header bytes hold no reset value.
module adts_frame_sync_deframer_top #(
  parameter int QDEPTH = adts_pkg::QDEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_end_of_input,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_frame_byte,
  output logic                         out_first_of_frame,
  output logic                         out_last_of_frame,
  output logic [adts_pkg::LEN_W-1:0]   out_frame_length,
  output logic [1:0]                   out_status
);

  localparam int CW = $clog2(QDEPTH + 1);

  // input register
  logic       ir_valid_r;
  logic [7:0] ir_byte_r;
  logic       ir_eoi_r;

  logic                                    adv;
  logic                                    fire;
  logic [adts_pkg::NRES_W-1:0]             res_n;
  adts_pkg::res_t [adts_pkg::MAX_RES-1:0]  res;
  adts_pkg::res_t                          head;
  logic [CW-1:0]                           q_count;

  // room for a worst-case burst, judged from registered count only
  assign adv      = (q_count <= CW'(QDEPTH - adts_pkg::MAX_RES));
  assign fire     = ir_valid_r && adv;
  assign in_stall = ir_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (!ir_valid_r || adv) begin
      ir_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_byte_r <= in_data_byte;
      ir_eoi_r  <= in_end_of_input;
    end
  end

  adts_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .data_byte    (ir_byte_r),
    .end_of_input (ir_eoi_r),
    .res_n        (res_n),
    .res          (res)
  );

  adts_rq #(
    .DEPTH (QDEPTH)
  ) u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (res_n),
    .push_res (res),
    .pop      (out_valid && !out_stall),
    .head     (head),
    .count    (q_count)
  );

  assign out_valid          = (q_count != '0);
  assign out_frame_byte     = head.frame_byte;
  assign out_first_of_frame = head.first_of_frame;
  assign out_last_of_frame  = head.last_of_frame;
  assign out_frame_length   = head.frame_length;
  assign out_status         = head.status;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // Receiver stall patterns, picked at random for stretches of cycles.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  localparam int unsigned LONG_HOLD    = 120;  // cycles of forced out_stall
  localparam int unsigned DRAIN_CYCLES = 24;   // tail after the last result
  localparam int unsigned RANDOM_BYTES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_data_byte = 8'h00;
  logic                       in_end_of_input = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 out_frame_byte;
  logic                       out_first_of_frame;
  logic                       out_last_of_frame;
  logic [adts_pkg::LEN_W-1:0] out_frame_length;
  logic [1:0]                 out_status;

  adts_frame_sync_deframer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_first_of_frame(out_first_of_frame),
    .out_last_of_frame (out_last_of_frame),
    .out_frame_length  (out_frame_length),
    .out_status        (out_status)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Deframer prediction: a software copy of the parser state. Every
  // accepted byte is run through it and the results it causes are queued
  // in order of arrival.
  // ---------------------------------------------------------------------
  adts_pkg::phase_t           dp_phase   = adts_pkg::PH_HUNT;
  logic                       dp_prev_ff = 1'b0;
  logic [7:0]                 dp_hdr [adts_pkg::HDR_STORE];
  logic [adts_pkg::LEN_W-1:0] dp_count   = '0;
  logic [adts_pkg::LEN_W-1:0] dp_len     = '0;

  adts_pkg::res_t frame_results_due[$];

  // Run statistics for the closing summary.
  int unsigned bytes_sent    = 0;
  int unsigned frames_done   = 0;
  int unsigned bad_len_seen  = 0;
  int unsigned trunc_seen    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;

  function automatic adts_pkg::res_t frame_result(input logic [7:0] fbyte,
                                                  input logic first,
                                                  input logic last,
                                                  input logic [adts_pkg::LEN_W-1:0] flen,
                                                  input logic [1:0] st);
    adts_pkg::res_t r;
    r.frame_byte     = fbyte;
    r.first_of_frame = first;
    r.last_of_frame  = last;
    r.frame_length   = flen;
    r.status         = st;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input logic eoi);
    logic [adts_pkg::LEN_W-1:0] flen;
    case (dp_phase)
      adts_pkg::PH_HEADER: begin
        if (dp_count < adts_pkg::HDR_STORED) begin
          dp_hdr[dp_count[2:0]] = b;
          dp_count++;
        end else begin
          // 13-bit length spread over header bytes 3..5
          flen   = {dp_hdr[3][1:0], dp_hdr[4], dp_hdr[5][7:5]};
          dp_len = flen;
          if (flen < adts_pkg::HDR_LEN) begin
            frame_results_due.push_back(frame_result(8'h00, 1'b0, 1'b1, flen,
                                                     adts_pkg::ST_BADLEN));
            bad_len_seen++;
            dp_phase   = adts_pkg::PH_HUNT;
            dp_prev_ff = 1'b0;
            dp_count   = '0;
          end else begin
            for (int i = 0; i < adts_pkg::HDR_STORE; i++)
              frame_results_due.push_back(frame_result(dp_hdr[i], i == 0, 1'b0, flen,
                                                       adts_pkg::ST_BYTE));
            frame_results_due.push_back(frame_result(b, 1'b0, flen == adts_pkg::HDR_LEN,
                                                     flen, adts_pkg::ST_BYTE));
            dp_count = adts_pkg::HDR_LEN;
            if (flen == adts_pkg::HDR_LEN) begin
              frames_done++;
              dp_phase   = adts_pkg::PH_HUNT;
              dp_prev_ff = 1'b0;
              dp_count   = '0;
            end else begin
              dp_phase = adts_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      adts_pkg::PH_PAYLOAD: begin
        dp_count++;
        if (dp_count >= dp_len) begin
          frame_results_due.push_back(frame_result(b, 1'b0, 1'b1, dp_len,
                                                   adts_pkg::ST_BYTE));
          frames_done++;
          dp_phase   = adts_pkg::PH_HUNT;
          dp_prev_ff = 1'b0;
          dp_count   = '0;
        end else begin
          frame_results_due.push_back(frame_result(b, 1'b0, 1'b0, dp_len,
                                                   adts_pkg::ST_BYTE));
        end
      end
      default: begin
        dp_phase = adts_pkg::PH_HUNT;
        if (dp_prev_ff && b[7:4] == adts_pkg::SYNC_NIB) begin
          dp_hdr[0]  = adts_pkg::SYNC_BYTE;
          dp_hdr[1]  = b;
          dp_count   = 13'd2;
          dp_len     = '0;
          dp_phase   = adts_pkg::PH_HEADER;
          dp_prev_ff = 1'b0;
        end else begin
          dp_prev_ff = (b == adts_pkg::SYNC_BYTE);
        end
      end
    endcase

    // End of stream closes any open frame with a truncation marker; the
    // length is only known once the header is complete.
    if (eoi) begin
      if (dp_phase != adts_pkg::PH_HUNT) begin
        frame_results_due.push_back(frame_result(8'h00, 1'b0, 1'b1,
                                                 (dp_phase == adts_pkg::PH_PAYLOAD) ?
                                                 dp_len : '0,
                                                 adts_pkg::ST_TRUNC));
        trunc_seen++;
      end
      dp_phase   = adts_pkg::PH_HUNT;
      dp_prev_ff = 1'b0;
      dp_count   = '0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: compare each transfer against the oldest expectation,
  // then pick out_stall for the next cycle.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result();
    adts_pkg::res_t want;
    if (frame_results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte=%02h status=%0d",
                                out_frame_byte, out_status));
      return;
    end
    want = frame_results_due.pop_front();
    results_seen++;
    if (out_frame_byte !== want.frame_byte)
      report_mismatch($sformatf("frame_byte %02h, want %02h", out_frame_byte,
                                want.frame_byte));
    if (out_first_of_frame !== want.first_of_frame)
      report_mismatch($sformatf("first_of_frame %b, want %b", out_first_of_frame,
                                want.first_of_frame));
    if (out_last_of_frame !== want.last_of_frame)
      report_mismatch($sformatf("last_of_frame %b, want %b", out_last_of_frame,
                                want.last_of_frame));
    if (out_frame_length !== want.frame_length)
      report_mismatch($sformatf("frame_length %0d, want %0d", out_frame_length,
                                want.frame_length));
    if (out_status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
  endtask

  // Long hold requests come from the test sequence; the receiver counts the
  // hold itself so only this process writes its counters.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_left       = 0;
  rx_mode_t    rx_mode       = RX_OPEN;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_result();

    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (rx_left == 0) begin
      rx_left = $urandom_range(8, 40);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    end
    rx_left--;

    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Byte sender: bursts of random length with random gaps in between.
  // Valid only drops at the start of a nonzero gap and rises again once the
  // gap is over, so valid is never lowered and raised in the same step.
  int unsigned burst_left    = 0;
  bit          sender_steady = 1'b0;

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    deframe_byte(b, eoi);
    bytes_sent++;
  endtask

  // One ADTS frame announcing length flen; only the first n_bytes go out,
  // with end of input on the last one sent when eoi_last is set. Bad
  // lengths stop after the seven header bytes.
  task automatic send_frame(input logic [adts_pkg::LEN_W-1:0] flen,
                            input int unsigned n_bytes, input bit eoi_last);
    int unsigned total;
    logic [7:0]  b;
    total = (flen < adts_pkg::HDR_LEN) ? adts_pkg::HDR_LEN : flen;
    if (n_bytes < total)
      total = n_bytes;
    for (int unsigned i = 0; i < total; i++) begin
      b = 8'($urandom);
      case (i)
        0:       b      = adts_pkg::SYNC_BYTE;
        1:       b[7:4] = adts_pkg::SYNC_NIB;
        3:       b[1:0] = flen[12:11];
        4:       b      = flen[10:3];
        5:       b[7:5] = flen[2:0];
        default: ;
      endcase
      send_byte(b, eoi_last && (i == total - 1));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Shortest legal frame, entered after a stray 0xFF that is not followed
  // by the sync nibble: the seventh header byte closes the frame.
  task automatic test_min_frame();
    send_byte(adts_pkg::SYNC_BYTE, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_frame(adts_pkg::HDR_LEN, adts_pkg::HDR_LEN, 1'b0);
  endtask

  // Length zero gives a single bad-length marker; end of input on the same
  // byte adds nothing since hunting has resumed.
  task automatic test_bad_length();
    send_frame(13'd0, adts_pkg::HDR_LEN, 1'b1);
  endtask

  // Stream ends in the payload of a maximum-length frame, then in a header.
  task automatic test_truncation();
    send_frame(13'h1FFF, 8, 1'b1);
    send_frame(13'd20, 3, 1'b1);
  endtask

  // A sync byte ending the stream must not pair with the next byte.
  task automatic test_eoi_while_hunting();
    send_byte(adts_pkg::SYNC_BYTE, 1'b1);
    send_byte(8'hF0, 1'b0);
  endtask

  // Receiver holds off long while the sender keeps pushing a long frame,
  // so the result queue fills and in_stall rises.
  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_requests++;
    send_frame(13'd48, 48, 1'b0);
    send_frame(13'd9, 9, 1'b0);
    sender_steady = 1'b0;
  endtask

  // Mostly well-formed frames with random content; some bad lengths,
  // truncated frames (short and long announced lengths) and noise bytes.
  task automatic test_random_stream();
    int unsigned start;
    int unsigned pick;
    int unsigned flen;
    int unsigned stop;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        flen = $urandom_range(7, 24);
        send_frame(adts_pkg::LEN_W'(flen), flen, $urandom_range(0, 5) == 0);
      end else if (pick < 15) begin
        send_frame(adts_pkg::LEN_W'($urandom_range(0, 6)), adts_pkg::HDR_LEN,
                   $urandom_range(0, 3) == 0);
      end else if (pick < 17) begin
        flen = $urandom_range(0, 1) ? $urandom_range(7, 40) : $urandom_range(7, 8191);
        stop = (flen - 1 < 20) ? flen - 1 : 20;
        send_frame(adts_pkg::LEN_W'(flen), $urandom_range(1, stop), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte($urandom_range(0, 1) ? adts_pkg::SYNC_BYTE : 8'($urandom),
                    $urandom_range(0, 7) == 0);
      end
    end
    sender_steady = 1'b0;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sequence: reset once, directed cases, pressure, random stream, drain.
  // ---------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_min_frame();
    test_bad_length();
    test_truncation();
    test_eoi_while_hunting();
    test_backpressure();
    test_random_stream();
    wait_for_results();

    $display("Sent %0d bytes: %0d whole frames, %0d bad-length markers, %0d truncations.",
             bytes_sent, frames_done, bad_len_seen, trunc_seen);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && frame_results_due.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Timeout with %0d results outstanding.", frame_results_due.size());
    $display("tb failed");
    $finish;
  end

endmodule
